FILE: rtl/core/swm_pkg.sv
// Shared constants, codes and types of the sliding window minimum block.
package swm_pkg;

    localparam int SWM_WINDOW_MAX  = 1024;
    localparam int SWM_SAMPLE_WIDTH = 32;
    localparam int SWM_INDEX_W     = 32;
    localparam int SWM_LEN_W       = 11;
    localparam int SWM_LEN_MIN     = 2;
    localparam int SWM_APB_DW      = 32;
    localparam int SWM_APB_AW      = 3;

    localparam logic [SWM_LEN_W-1:0] SWM_LEN_DEFAULT = SWM_LEN_W'(30);
    localparam logic [SWM_LEN_W-1:0] SWM_AGE_TOP     = '1;

    localparam logic [SWM_APB_AW-3:0] SWM_REG_WINDOW_LENGTH = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MIN_NOP,
        MIN_AGE_TOP,
        MIN_ADVANCE,
        MIN_OFFER,
        MIN_SCAN
    } t_min_op;

    typedef struct packed {
        t_min_op              op;
        logic                 first;
        logic [SWM_LEN_W-1:0] age;
    } t_min_cmd;

endpackage

FILE: rtl/core/swm_if.sv
// Valid/ready channel interfaces for samples in and window minima out.
interface swm_in_if
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) ();
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    series_start;
    logic                    series_end;

    modport source (output valid, output sample, output series_start, output series_end,
                    input ready);
    modport sink (input valid, input sample, input series_start, input series_end,
                  output ready);
endinterface

interface swm_out_if
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) ();
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] minimum;
    logic [SWM_INDEX_W-1:0]  sample_index;
    logic                    last;

    modport source (output valid, output minimum, output sample_index, output last,
                    input ready);
    modport sink (input valid, input minimum, input sample_index, input last,
                  output ready);
endinterface

FILE: rtl/core/swm_store.sv
// Ring store of window samples: one write port, one registered read port.
module swm_store
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = SWM_WINDOW_MAX,
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH,
    parameter int PTR_W        = $clog2(WINDOW_MAX)
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [PTR_W-1:0]        i_wr_addr,
    input  logic [SAMPLE_WIDTH-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [PTR_W-1:0]        i_rd_addr,
    output logic [SAMPLE_WIDTH-1:0] o_rd_data
);

    logic [SAMPLE_WIDTH-1:0] r_mem [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/swm_min_unit.sv
// Shared signed compare unit holding the current minimum and its age.
module swm_min_unit
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_min_cmd                i_cmd,
    input  logic [SAMPLE_WIDTH-1:0] i_data,
    output logic [SAMPLE_WIDTH-1:0] o_min,
    output logic [SWM_LEN_W-1:0]    o_age
);

    logic [SAMPLE_WIDTH-1:0] r_min;
    logic [SAMPLE_WIDTH-1:0] n_min;
    logic [SWM_LEN_W-1:0]    r_age;
    logic [SWM_LEN_W-1:0]    n_age;
    logic                    s_lt;
    logic                    s_eq;

    assign s_lt = $signed(i_data) < $signed(r_min);
    assign s_eq = i_data == r_min;

    always_comb begin
        n_min = r_min;
        n_age = r_age;
        case (i_cmd.op)
            MIN_NOP: begin
            end
            MIN_AGE_TOP: begin
                n_age = SWM_AGE_TOP;
            end
            MIN_ADVANCE: begin
                if (i_cmd.first) begin
                    n_age = SWM_LEN_W'(1);
                end else if (r_age != SWM_AGE_TOP) begin
                    n_age = r_age + SWM_LEN_W'(1);
                end
            end
            MIN_OFFER: begin
                if (s_lt || s_eq) begin
                    n_min = i_data;
                    n_age = i_cmd.age;
                end
            end
            MIN_SCAN: begin
                if (i_cmd.first || s_lt) begin
                    n_min = i_data;
                    n_age = i_cmd.age;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_age <= '0;
        end else begin
            r_min <= n_min;
            r_age <= n_age;
        end
    end

    assign o_min = r_min;
    assign o_age = r_age;

endmodule

FILE: rtl/core/sliding_window_minimum_core.sv
// Top level of the sliding window minimum block: sequencer, counters, APB register.
//
// Samples enter on i_in (valid/ready); results leave on o_out (valid/ready), zero or
// one result per sample. The first window_length-1 samples of a series give no result.
// window_length sits at APB address 0 (reset value 30, writes clamp to 2..WINDOW_MAX)
// and must be written only while the block is idle; nothing in the block checks this.
// One sample is worked on at a time; i_in.ready is high only in the idle state.
// A sample that only moves the running minimum passes through the evaluate and output
// states; its result is registered as the block returns to idle for the next sample.
// A filling sample (no result) passes through the evaluate state back to idle.
// When the minimum leaves the window, the window is rescanned through the single
// store read port and the shared compare unit, one entry per cycle, before the result
// is registered in the output state.
// Reset (synchronous, active low) empties the series and restores window_length;
// the store needs no clearing pass, its entries are read only after being written.
// A stalled receiver holds the result in the output register; the block still takes
// the next sample and holds in its output state until the register frees.
module sliding_window_minimum_core
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX   = SWM_WINDOW_MAX,
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swm_in_if.sink                i_in,
    swm_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [SWM_APB_AW-1:0] paddr,
    input  logic [SWM_APB_DW-1:0] pwdata,
    output logic [SWM_APB_DW-1:0] prdata,
    output logic                  pready
);

    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
    localparam int CW      = ((FILL_W > SWM_LEN_W) ? FILL_W : SWM_LEN_W) + 1;
    localparam int LEN_TOP = (1 << SWM_LEN_W) - 1;
    localparam int LEN_CAP = (WINDOW_MAX > LEN_TOP) ? LEN_TOP : WINDOW_MAX;

    t_state                   r_state;
    t_state                   n_state;
    logic [SWM_LEN_W-1:0]     r_len;
    logic [PTR_W-1:0]         r_wp;
    logic [FILL_W-1:0]        r_fill;
    logic [SWM_INDEX_W-1:0]   r_idx;
    logic [SAMPLE_WIDTH-1:0]  r_sample;
    logic [SWM_INDEX_W-1:0]   r_this_idx;
    logic                     r_end;
    logic [PTR_W-1:0]         r_rd_addr;
    logic [SWM_LEN_W-1:0]     r_rd_left;
    logic [SWM_LEN_W-1:0]     r_scan_age;
    logic                     r_scan_first;
    logic                     r_d_vld;
    logic                     r_d_first;
    logic [SWM_LEN_W-1:0]     r_d_age;
    logic                     r_out_vld;
    logic [SAMPLE_WIDTH-1:0]  r_out_min;
    logic [SWM_INDEX_W-1:0]   r_out_idx;
    logic                     r_out_last;

    logic                     s_acc;
    logic                     s_in_ready;
    logic                     s_cfg_hit;
    logic [SWM_LEN_W-1:0]     s_wr_len;
    logic [SWM_LEN_W-1:0]     n_len;
    logic [PTR_W-1:0]         s_eff_wp;
    logic [FILL_W-1:0]        s_eff_fill;
    logic [SWM_INDEX_W-1:0]   s_eff_idx;
    logic                     s_filling;
    logic                     s_stale;
    logic [CW-1:0]            s_wp_ext;
    logic [CW-1:0]            s_len_ext;
    logic [CW-1:0]            s_pos_ext;
    logic                     s_scan_init;
    logic                     s_scan_issue;
    logic                     s_out_load;
    t_min_cmd                 s_cmd;
    logic [SAMPLE_WIDTH-1:0]  s_cmd_data;
    logic [SAMPLE_WIDTH-1:0]  s_rd_data;
    logic [SAMPLE_WIDTH-1:0]  s_min;
    logic [SWM_LEN_W-1:0]     s_age;

    // APB register
    assign pready    = 1'b1;
    assign s_cfg_hit = psel && penable && pwrite
                       && (paddr[SWM_APB_AW-1:2] == SWM_REG_WINDOW_LENGTH);
    assign s_wr_len  = pwdata[SWM_LEN_W-1:0];

    always_comb begin
        if (s_wr_len < SWM_LEN_W'(SWM_LEN_MIN)) begin
            n_len = SWM_LEN_W'(SWM_LEN_MIN);
        end else if (s_wr_len > SWM_LEN_W'(LEN_CAP)) begin
            n_len = SWM_LEN_W'(LEN_CAP);
        end else begin
            n_len = s_wr_len;
        end
    end

    always_comb begin
        if (paddr[SWM_APB_AW-1:2] == SWM_REG_WINDOW_LENGTH) begin
            prdata = SWM_APB_DW'(r_len);
        end else begin
            prdata = '0;
        end
    end

    // per-transfer counters
    assign s_acc      = i_in.valid && s_in_ready;
    assign i_in.ready = s_in_ready;
    assign s_eff_wp   = i_in.series_start ? '0 : r_wp;
    assign s_eff_fill = i_in.series_start ? '0 : r_fill;
    assign s_eff_idx  = i_in.series_start ? '0 : r_idx;

    assign s_filling = CW'(r_fill) < CW'(r_len);
    assign s_stale   = s_age >= r_len;

    assign s_wp_ext  = CW'(r_wp);
    assign s_len_ext = CW'(r_len);
    assign s_pos_ext = (s_wp_ext >= s_len_ext) ? (s_wp_ext - s_len_ext)
                                               : (s_wp_ext + CW'(WINDOW_MAX) - s_len_ext);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (s_filling) begin
                    n_state = ST_IDLE;
                end else if (s_stale) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: begin
                if ((r_rd_left == '0) && !r_d_vld) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_vld || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        s_in_ready   = 1'b0;
        s_scan_init  = 1'b0;
        s_scan_issue = 1'b0;
        s_out_load   = 1'b0;
        s_cmd.op     = MIN_NOP;
        s_cmd.first  = 1'b0;
        s_cmd.age    = '0;
        s_cmd_data   = r_sample;
        case (r_state)
            ST_IDLE: begin
                s_in_ready = 1'b1;
                if (i_in.valid) begin
                    s_cmd.op    = MIN_ADVANCE;
                    s_cmd.first = i_in.series_start;
                end
            end
            ST_EVAL: begin
                if (s_filling) begin
                    s_cmd.op = MIN_AGE_TOP;
                end else if (s_stale) begin
                    s_scan_init = 1'b1;
                end else begin
                    s_cmd.op = MIN_OFFER;
                end
            end
            ST_SCAN: begin
                s_scan_issue = r_rd_left != '0;
                if (r_d_vld) begin
                    s_cmd.op    = MIN_SCAN;
                    s_cmd.first = r_d_first;
                    s_cmd.age   = r_d_age;
                    s_cmd_data  = s_rd_data;
                end
            end
            ST_EMIT: begin
                s_out_load = !r_out_vld || o_out.ready;
            end
            default: begin
            end
        endcase
        if (s_cfg_hit) begin
            s_cmd.op = MIN_AGE_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= SWM_LEN_DEFAULT;
            r_wp      <= '0;
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_left <= '0;
            r_d_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_cfg_hit) begin
                r_len <= n_len;
            end
            if (s_acc) begin
                r_wp <= (s_eff_wp == PTR_W'(WINDOW_MAX - 1)) ? '0 : s_eff_wp + PTR_W'(1);
                if (s_eff_fill != FILL_W'(WINDOW_MAX)) begin
                    r_fill <= s_eff_fill + FILL_W'(1);
                end else begin
                    r_fill <= s_eff_fill;
                end
                if (s_eff_idx != '1) begin
                    r_idx <= s_eff_idx + SWM_INDEX_W'(1);
                end else begin
                    r_idx <= s_eff_idx;
                end
            end
            if (s_scan_init) begin
                r_rd_left <= r_len;
            end else if (s_scan_issue) begin
                r_rd_left <= r_rd_left - SWM_LEN_W'(1);
            end
            r_d_vld <= s_scan_issue;
            if (s_out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload: hold the item, walk the read address, carry age with each read
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_sample   <= i_in.sample;
            r_this_idx <= s_eff_idx;
            r_end      <= i_in.series_end;
        end
        if (s_scan_init) begin
            r_rd_addr    <= s_pos_ext[PTR_W-1:0];
            r_scan_age   <= r_len - SWM_LEN_W'(1);
            r_scan_first <= 1'b1;
        end else if (s_scan_issue) begin
            r_rd_addr    <= (r_rd_addr == PTR_W'(WINDOW_MAX - 1)) ? '0
                                                                : r_rd_addr + PTR_W'(1);
            r_scan_age   <= r_scan_age - SWM_LEN_W'(1);
            r_scan_first <= 1'b0;
        end
        if (s_scan_issue) begin
            r_d_first <= r_scan_first;
            r_d_age   <= r_scan_age;
        end
        if (s_out_load) begin
            r_out_min  <= s_min;
            r_out_idx  <= r_this_idx;
            r_out_last <= r_end;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.minimum      = r_out_min;
    assign o_out.sample_index = r_out_idx;
    assign o_out.last         = r_out_last;

    swm_store #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .PTR_W        (PTR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (s_acc),
        .i_wr_addr (s_eff_wp),
        .i_wr_data (i_in.sample),
        .i_rd_en   (s_scan_issue),
        .i_rd_addr (r_rd_addr),
        .o_rd_data (s_rd_data)
    );

    swm_min_unit #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_min_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (s_cmd),
        .i_data  (s_cmd_data),
        .o_min   (s_min),
        .o_age   (s_age)
    );

`ifndef SYNTH
    a_acc_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == ST_EVAL))
        else $error("transfer not followed by evaluation");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len >= SWM_LEN_W'(SWM_LEN_MIN)) && (r_len <= SWM_LEN_W'(LEN_CAP)))
        else $error("window length out of range");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= PTR_W'(WINDOW_MAX - 1)) && (r_fill <= FILL_W'(WINDOW_MAX)))
        else $error("write pointer or fill count out of range");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_vld |-> (r_state == ST_SCAN))
        else $error("store read data outside rescan");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == ST_EMIT))
        else $error("result registered outside output state");
`endif

endmodule
